// File: rtl/vhd_pkg.sv
package vhd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 28;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CntW    = 3;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned DataW   = 32;

  // widest varint length field, in bytes (4)
  localparam logic [CntW-1:0] MaxLenBytes = 3'd4;

  localparam logic [1:0] PhType    = 2'd0;
  localparam logic [1:0] PhLen     = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;
  localparam logic [1:0] PhAlert   = 2'd3;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StNoTerm   = 3'd1;
  localparam logic [StatusW-1:0] StTooLong  = 3'd2;
  localparam logic [StatusW-1:0] StTooShort = 3'd3;
  localparam logic [StatusW-1:0] StTooWide  = 3'd4;

  localparam logic RegAlertType  = 1'b0;
  localparam logic RegMaxPayload = 1'b1;

  localparam logic [ByteW-1:0] AlertTypeRst  = 8'd0;
  localparam logic [LenW-1:0]  MaxPayloadRst = 28'd2048;

  typedef struct packed {
    logic [ByteW-1:0] alert_type;
    logic [LenW-1:0]  max_payload;
  } cfg_t;

endpackage

// File: rtl/vhd_cfg.sv
module vhd_cfg import vhd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [ByteW-1:0] alert_type_q;
  logic [LenW-1:0]  max_payload_q;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alert_type_q  <= AlertTypeRst;
      max_payload_q <= MaxPayloadRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegAlertType:  alert_type_q  <= pwdata[ByteW-1:0];
        RegMaxPayload: max_payload_q <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegAlertType:  prdata = {{(DataW-ByteW){1'b0}}, alert_type_q};
      RegMaxPayload: prdata = {{(DataW-LenW){1'b0}}, max_payload_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.alert_type  = alert_type_q;
  assign cfg_o.max_payload = max_payload_q;

endmodule

// File: rtl/varint_header_deframer.sv
// Datagram deframer. Takes one byte word per cycle with an end-of-datagram
// flag: the first byte is the message type; unless it matches alert_type a
// little-endian base-128 varint length follows, then the payload. Payload
// bytes come out as they arrive; the datagram's last byte yields a word with
// frame_end set carrying type, length and status. Bytes that neither carry
// payload nor end the datagram produce no output word. Throughput is one
// byte per cycle unless stalled; each byte passes the input register, then
// the header state update into the output register. A stall on the output
// stalls the input only while a result word waits and the next byte emits.
module varint_header_deframer import vhd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  input  logic               end_of_datagram_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   out_byte_o,
  output logic               byte_valid_o,
  output logic               frame_end_o,
  output logic [ByteW-1:0]   frame_type_o,
  output logic [LenW-1:0]    frame_length_o,
  output logic [StatusW-1:0] status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  cfg_t cfg;

  vhd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // frame state
  logic [1:0]         ph_q, ph_d;
  logic [ByteW-1:0]   typ_q, typ_d;
  logic [LenW-1:0]    acc_q, acc_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [LenW-1:0]    pc_q, pc_d;
  logic [StatusW-1:0] err_q, err_d;

  // output register
  logic               out_vld_q;
  logic [ByteW-1:0]   out_byte_q;
  logic               out_bv_q;
  logic               out_end_q;
  logic [ByteW-1:0]   out_typ_q;
  logic [LenW-1:0]    out_len_q;
  logic [StatusW-1:0] out_st_q;

  logic               pay_vld;
  logic [LenW-1:0]    flen;
  logic [StatusW-1:0] st;
  logic [5:0]         sh;
  logic [34:0]        shifted;
  logic               emit;
  logic               adv;

  always_comb begin
    ph_d    = ph_q;
    typ_d   = typ_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    pc_d    = pc_q;
    err_d   = err_q;
    pay_vld = 1'b0;
    flen    = '0;
    st      = StOk;
    sh      = 6'(cnt_q) * 6'd7;
    shifted = 35'(in_byte_q[6:0]) << sh;

    if (ph_q == PhType) begin
      typ_d = in_byte_q;
      ph_d  = (in_byte_q == cfg.alert_type) ? PhAlert : PhLen;
    end else if (err_q != StOk) begin
      // rest of a failed datagram is dropped
    end else if (ph_q == PhLen) begin
      if (cnt_q >= MaxLenBytes) begin
        err_d = StTooWide;
      end else if (shifted[34:LenW] != '0) begin
        err_d = StTooWide;
      end else begin
        acc_d = acc_q | shifted[LenW-1:0];
        cnt_d = cnt_q + 3'd1;
        if (!in_byte_q[7]) begin
          if (acc_d > cfg.max_payload) err_d = StTooLong;
          else                         ph_d  = PhPayload;
        end else if (cnt_d >= MaxLenBytes) begin
          err_d = StTooWide;
        end
      end
    end else if (ph_q == PhPayload) begin
      if (pc_q < acc_q) begin
        pc_d    = pc_q + 28'd1;
        pay_vld = 1'b1;
      end
    end else begin
      if (pc_q < cfg.max_payload) pay_vld = 1'b1;
      else                        err_d   = StTooLong;
      if (pc_q != '1) pc_d = pc_q + 28'd1;
    end

    if (in_last_q) begin
      if (err_d != StOk) begin
        st   = err_d;
        flen = (ph_d == PhAlert) ? pc_d : acc_d;
      end else if (ph_d == PhAlert) begin
        flen = pc_d;
      end else if (ph_d == PhLen) begin
        st   = StNoTerm;
        flen = acc_d;
      end else begin
        flen = acc_d;
        st   = (pc_d < acc_d) ? StTooShort : StOk;
      end
    end
  end

  assign emit       = pay_vld || in_last_q;
  assign adv        = in_vld_q && (!emit || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
      in_last_q <= end_of_datagram_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PhType;
      typ_q <= '0;
      acc_q <= '0;
      cnt_q <= '0;
      pc_q  <= '0;
      err_q <= StOk;
    end else if (adv) begin
      if (in_last_q) begin
        ph_q  <= PhType;
        typ_q <= '0;
        acc_q <= '0;
        cnt_q <= '0;
        pc_q  <= '0;
        err_q <= StOk;
      end else begin
        ph_q  <= ph_d;
        typ_q <= typ_d;
        acc_q <= acc_d;
        cnt_q <= cnt_d;
        pc_q  <= pc_d;
        err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_byte_q <= pay_vld ? in_byte_q : '0;
      out_bv_q   <= pay_vld;
      out_end_q  <= in_last_q;
      out_typ_q  <= typ_d;
      out_len_q  <= flen;
      out_st_q   <= st;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_byte_o     = out_byte_q;
  assign byte_valid_o   = out_bv_q;
  assign frame_end_o    = out_end_q;
  assign frame_type_o   = out_typ_q;
  assign frame_length_o = out_len_q;
  assign status_o       = out_st_q;

endmodule

// File: rtl/vhd_checker.sv
module vhd_checker import vhd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ByteW-1:0]   out_byte_o,
  input logic               byte_valid_o,
  input logic               frame_end_o,
  input logic [LenW-1:0]    frame_length_o,
  input logic [StatusW-1:0] status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(frame_end_o) && $stable(status_o))
    else $error("output word changed while stalled");

  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> frame_end_o)
    else $error("output word with neither payload nor frame end");

  a_mid_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> status_o == StOk && frame_length_o == '0)
    else $error("summary fields set before frame end");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_byte_o == '0)
    else $error("out_byte nonzero without payload");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= StTooWide)
    else $error("status code out of range");

endmodule

bind varint_header_deframer vhd_checker u_vhd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_byte_o     (out_byte_o),
  .byte_valid_o   (byte_valid_o),
  .frame_end_o    (frame_end_o),
  .frame_length_o (frame_length_o),
  .status_o       (status_o)
);

// File: sim/tb_varint_header_deframer.sv
`timescale 1ns / 1ps

module tb_varint_header_deframer;
  import vhd_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandWords  = 1550;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned LenAll     = 32'h0FFF_FFFF;

  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic               byte_valid;
    logic               frame_end;
    logic [ByteW-1:0]   frame_type;
    logic [LenW-1:0]    frame_length;
    logic [StatusW-1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             eod;
    logic             typed;
    out_word_t        want;
  } hdr_row_t;

  localparam int unsigned NumRows = 27;
  localparam hdr_row_t HdrRows [NumRows] = '{
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 8'h00, 28'd0, StOk}},
    '{8'h05, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 8'h05, 28'd0, StNoTerm}},
    '{8'h07, 1'b0, 1'b0, '0},
    '{8'h83, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 8'h07, 28'd3, StNoTerm}},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 8'h01, 28'd2, StOk}},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'haa, 1'b1, 1'b1, '{8'haa, 1'b1, 1'b1, 8'h02, 28'd3, StTooShort}},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'h81, 1'b0, 1'b0, '0},
    '{8'h11, 1'b0, 1'b0, '0},
    '{8'h55, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 8'h03, 28'd2177, StTooLong}},
    '{8'h04, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 8'h04, 28'hfff_ffff, StTooWide}},
    '{8'h10, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h7e, 1'b0, 1'b0, '0},
    '{8'h33, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 8'h10, 28'd1, StOk}},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h01, 1'b1, 1'b1, '{8'h01, 1'b1, 1'b1, 8'h00, 28'd2, StOk}}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   rx_byte_i = '0;
  logic               end_of_datagram_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [ByteW-1:0]   out_byte_o;
  logic               byte_valid_o;
  logic               frame_end_o;
  logic [ByteW-1:0]   frame_type_o;
  logic [LenW-1:0]    frame_length_o;
  logic [StatusW-1:0] status_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PaddrW-1:0]  paddr = '0;
  logic [DataW-1:0]   pwdata = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  varint_header_deframer u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .rx_byte_i, .end_of_datagram_i,
    .out_valid_o, .out_stall_i, .out_byte_o, .byte_valid_o, .frame_end_o,
    .frame_type_o, .frame_length_o, .status_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // deframer shadow: configuration and per-datagram state
  logic [ByteW-1:0]   cfg_alert = 8'd0;
  logic [LenW-1:0]    cfg_max = 28'd2048;
  logic [1:0]         hdr_phase = PhType;
  logic [ByteW-1:0]   type_seen = '0;
  logic [LenW-1:0]    len_acc = '0;
  logic [CntW-1:0]    len_nbytes = '0;
  logic [LenW-1:0]    pay_count = '0;
  logic [StatusW-1:0] frame_err = StOk;

  out_word_t        words_due [$];
  logic [ByteW-1:0] dgram [$];
  int unsigned      words_in = 0;
  int unsigned      errors = 0;
  int unsigned      cycle_cnt = 0;
  int unsigned      burst_left = 0;
  bit               gappy = 1'b1;

  task automatic deframe_byte(input logic [ByteW-1:0] b, input logic eod,
                              output bit got, output out_word_t w);
    logic [63:0]        v;
    logic               vld;
    logic [LenW-1:0]    flen;
    logic [StatusW-1:0] st;
    vld  = 1'b0;
    flen = '0;
    st   = StOk;
    if (hdr_phase == PhType) begin
      type_seen = b;
      hdr_phase = (b == cfg_alert) ? PhAlert : PhLen;
    end else if (frame_err != StOk) begin
      // rest of a failed datagram is dropped
    end else if (hdr_phase == PhLen) begin
      if (len_nbytes >= MaxLenBytes) begin
        frame_err = StTooWide;
      end else begin
        v = 64'(b[6:0]) << (7 * len_nbytes);
        if (v[63:LenW] != 0) begin
          frame_err = StTooWide;
        end else begin
          len_acc = len_acc | v[LenW-1:0];
          len_nbytes++;
          if (!b[7]) begin
            if (len_acc > cfg_max) frame_err = StTooLong;
            else hdr_phase = PhPayload;
          end else if (len_nbytes >= MaxLenBytes) begin
            frame_err = StTooWide;
          end
        end
      end
    end else if (hdr_phase == PhPayload) begin
      if (pay_count < len_acc) begin
        pay_count++;
        vld = 1'b1;
      end
    end else begin
      if (pay_count < cfg_max) vld = 1'b1;
      else frame_err = StTooLong;
      if (pay_count != '1) pay_count++;
    end
    if (eod) begin
      flen = (hdr_phase == PhAlert) ? pay_count : len_acc;
      if (frame_err != StOk) st = frame_err;
      else if (hdr_phase == PhLen) st = StNoTerm;
      else if (hdr_phase == PhPayload && pay_count < len_acc) st = StTooShort;
    end
    got = vld || eod;
    w = '{vld ? b : 8'h00, vld, eod, type_seen, flen, st};
    if (eod) begin
      hdr_phase  = PhType;
      type_seen  = '0;
      len_acc    = '0;
      len_nbytes = '0;
      pay_count  = '0;
      frame_err  = StOk;
    end
  endtask

  task automatic send_word(input logic [ByteW-1:0] b, input logic eod,
                           input logic typed, input out_word_t want);
    int unsigned gap;
    bit          got;
    out_word_t   w;
    gap = 0;
    if (gappy) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    rx_byte_i         <= b;
    end_of_datagram_i <= eod;
    do @(posedge clk_i); while (in_stall_o);
    words_in++;
    deframe_byte(b, eod, got, w);
    if (typed) w = want;
    if (got) words_due.push_back(w);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [PaddrW-1:0] addr, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_varint(input logic [31:0] len, input bit pad);
    logic [31:0]      v;
    logic [ByteW-1:0] b;
    v = len;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0 || pad) b[7] = 1'b1;
      dgram.push_back(b);
    end while (v != 0);
    if (pad) dgram.push_back(8'h00);
  endtask

  task automatic build_datagram();
    int unsigned      kind;
    int unsigned      n;
    logic [31:0]      len;
    logic [31:0]      lim;
    logic [ByteW-1:0] ty;
    dgram.delete();
    kind = $urandom_range(0, 99);
    lim  = (cfg_max > 24) ? 24 : 32'(cfg_max);
    ty   = 8'($urandom_range(0, 255));
    if (ty == cfg_alert) ty = ty ^ 8'h01;
    if (kind < 25) begin
      dgram.push_back(cfg_alert);
      n = $urandom_range(0, lim + 3);
    end else if (kind < 70) begin
      dgram.push_back(ty);
      len = $urandom_range(0, lim);
      push_varint(len, $urandom_range(0, 7) == 0);
      n = len + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
    end else if (kind < 80) begin
      // payload cut short
      dgram.push_back(ty);
      len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, LenAll) : $urandom_range(1, lim + 1);
      push_varint(len, 1'b0);
      n = $urandom_range(0, (len > 25) ? 24 : len - 1);
    end else if (kind < 88) begin
      dgram.push_back(ty);
      if (cfg_max == LenAll) len = cfg_max;
      else len = cfg_max + 1 + $urandom_range(0, LenAll - cfg_max - 1);
      push_varint(len, 1'b0);
      n = $urandom_range(0, 3);
    end else if (kind < 95) begin
      // length field with continuation bytes that may leave it open or too wide
      dgram.push_back(ty);
      repeat ($urandom_range(1, 5)) dgram.push_back(8'h80 | 8'($urandom_range(0, 127)));
      n = $urandom_range(0, 3);
    end else begin
      n = $urandom_range(1, 6);
    end
    repeat (n) dgram.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  out_word_t want_w;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (words_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual byte %0h fe %0b type %0h len %0h st %0d",
                 $time, out_byte_o, frame_end_o, frame_type_o, frame_length_o, status_o);
        errors++;
      end else begin
        want_w = words_due.pop_front();
        check_field("out_byte", want_w.out_byte, out_byte_o);
        check_field("byte_valid", want_w.byte_valid, byte_valid_o);
        check_field("frame_end", want_w.frame_end, frame_end_o);
        check_field("frame_type", want_w.frame_type, frame_type_o);
        check_field("frame_length", want_w.frame_length, frame_length_o);
        check_field("status", want_w.status, status_o);
      end
    end
  end

  // receiver backpressure
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned stall_mode = 0;
  bit          held_once = 1'b0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!held_once && words_in >= 700) begin
      held_once   <= 1'b1;
      hold_left   <= 400;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_varint_header_deframer: done, errors");
      $finish;
    end
  end

  initial begin
    logic [ByteW-1:0] a;
    logic [LenW-1:0]  m;
    int unsigned      stop_at;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      send_word(HdrRows[i].rx, HdrRows[i].eod, HdrRows[i].typed, HdrRows[i].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      case (p)
        0: begin a = 8'hff; m = '0; end
        1: begin a = 8'h00; m = '1; end
        2: begin a = 8'h80; m = 28'd1; end
        default: begin
          a = 8'($urandom_range(0, 255));
          m = (p % 2) ? 28'($urandom_range(0, 40)) : 28'($urandom_range(41, 400));
        end
      endcase
      cfg_write({RegAlertType, 2'b00}, {24'b0, a});
      cfg_alert = a;
      cfg_write({RegMaxPayload, 2'b00}, {4'b0, m});
      cfg_max = m;
      gappy   = (p % 3 != 2);
      stop_at = words_in + RandWords / NumPhases;
      while (words_in < stop_at) begin
        build_datagram();
        for (int i = 0; i < dgram.size(); i++) begin
          send_word(dgram[i], i == dgram.size() - 1, 1'b0, '0);
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb_varint_header_deframer: done, clean");
    end else begin
      $display("tb_varint_header_deframer: done, errors");
    end
    $finish;
  end

endmodule
